// ===== rtl/core/p2rlcd_pkg.sv =====
package p2rlcd_pkg;

  // Framebuffer geometry
  localparam int FB_DEPTH = 1024;
  localparam int FB_AW    = $clog2(FB_DEPTH);
  localparam logic [FB_AW-1:0] FB_LAST = FB_AW'(FB_DEPTH - 1);

  // Request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STEP  = 2'd2;

  // Bus byte layout: two commands then sixteen pixel bytes per row
  localparam logic [4:0] POS_VCMD      = 5'd0;
  localparam logic [4:0] POS_HCMD      = 5'd1;
  localparam logic [4:0] POS_PIX_FIRST = 5'd2;
  localparam logic [4:0] ROW_BYTES     = 5'd18;

  localparam logic [7:0] CMD_BASE  = 8'h80;
  localparam logic [7:0] CMD_LOWER = 8'h88;

  localparam logic [6:0] FULL_STOP  = 7'd64;
  localparam logic [2:0] BAND_LAST  = 3'd4;
  localparam logic [3:0] GATHER_CNT = 4'd8;

  typedef struct packed {
    logic [1:0] req_type;
    logic [9:0] fb_address;
    logic [7:0] fb_data;
    logic       full_refresh;
  } p2rlcd_in_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       is_data;
    logic       last_of_refresh;
    logic [2:0] next_band;
  } p2rlcd_out_t;

  // Framebuffer access from the engine
  typedef struct packed {
    logic             we;
    logic             re;
    logic [FB_AW-1:0] addr;
    logic [7:0]       wdata;
  } p2rlcd_mem_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GATHER,
    ST_RESULT
  } p2rlcd_state_t;

  // First row of a band
  function automatic logic [6:0] band_first(input logic [2:0] b);
    logic [6:0] r;
    case (b)
      3'd1:    r = 7'd13;
      3'd2:    r = 7'd26;
      3'd3:    r = 7'd39;
      3'd4:    r = 7'd52;
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  // Row just past the end of a band
  function automatic logic [6:0] band_stop(input logic [2:0] b);
    logic [6:0] r;
    case (b)
      3'd1:    r = 7'd26;
      3'd2:    r = 7'd39;
      3'd3:    r = 7'd52;
      3'd4:    r = 7'd64;
      default: r = 7'd13;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/page_to_row_lcd_refresh_engine_unit.sv =====
// Channel  | Ports                          | Transaction
// input    | in_valid, in_ready, in_data    | write, start or step request
// result   | out_valid, out_ready, out_data | one bus byte per active step
//
// After reset the framebuffer is swept to zero with in_ready low. Write and
// start finish on acceptance; a command step goes to the result state; a pixel
// step first does eight sequential reads on the single framebuffer read port.
// One request is worked on at a time; a finished byte waits in the output
// register while the next request is taken; a step stalls only if that
// register is still full when its byte is ready.
module page_to_row_lcd_refresh_engine_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  p2rlcd_pkg::p2rlcd_in_t  in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output p2rlcd_pkg::p2rlcd_out_t out_data
);
  import p2rlcd_pkg::*;

  p2rlcd_mem_req_t mem_req;
  logic [7:0]      mem_rdata;
  logic            mem_busy;
  logic            out_free;
  logic            res_push;
  p2rlcd_out_t     res_data;

  logic            out_valid_r, out_valid_nxt;
  p2rlcd_out_t     out_data_r, out_data_nxt;

  p2rlcd_fb_mem u_fb_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rdata (mem_rdata),
    .busy  (mem_busy)
  );

  p2rlcd_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .mem_busy  (mem_busy),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .out_free  (out_free),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  // Output register
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_push) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/p2rlcd_fb_mem.sv =====
module p2rlcd_fb_mem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  p2rlcd_pkg::p2rlcd_mem_req_t req,
  output logic [7:0]                 rdata,
  output logic                       busy
);
  import p2rlcd_pkg::*;

  logic [7:0]       mem [0:FB_DEPTH-1];
  logic [7:0]       rdata_r;
  logic             clearing_r, clearing_nxt;
  logic [FB_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic             wr_en;
  logic [FB_AW-1:0] wr_addr;
  logic [7:0]       wr_data;

  // Clearing sweep after reset, one entry per cycle
  always_comb begin
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == FB_LAST) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Single write port shared by the sweep and the engine
  always_comb begin
    if (clearing_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else begin
      wr_en   = req.we;
      wr_addr = req.addr;
      wr_data = req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = clearing_r;

  // No engine access may collide with the sweep
  a_no_access_while_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> (!req.we && !req.re))
    else $error("framebuffer accessed during clearing sweep");

  // Sweep ends only after the last entry
  a_sweep_complete: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clearing_r) |-> $past(clr_addr_r) == FB_LAST)
    else $error("clearing sweep ended early");

  // Once finished, the sweep does not restart without reset
  a_sweep_once: assert property (@(posedge clk) disable iff (!rst_n)
    !clearing_r |=> !clearing_r)
    else $error("clearing sweep restarted");

endmodule

// ===== rtl/core/p2rlcd_engine.sv =====
module p2rlcd_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  p2rlcd_pkg::p2rlcd_in_t      in_data,
  output logic                        in_ready,
  input  logic                        mem_busy,
  output p2rlcd_pkg::p2rlcd_mem_req_t mem_req,
  input  logic [7:0]                  mem_rdata,
  input  logic                        out_free,
  output logic                        res_push,
  output p2rlcd_pkg::p2rlcd_out_t     res_data
);
  import p2rlcd_pkg::*;

  p2rlcd_state_t state_r, state_nxt;

  logic [2:0] band_r, band_nxt;
  logic       active_r, active_nxt;
  logic [6:0] row_r, row_nxt;
  logic [6:0] end_r, end_nxt;
  logic [4:0] pos_r, pos_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic       is_data_r, is_data_nxt;

  logic       accept;
  logic       step_go;
  logic       pixel;
  logic [4:0] group;
  logic [2:0] band_sel;
  logic [4:0] pos_inc;
  logic [6:0] row_inc;
  logic       last;

  assign in_ready = (state_r == ST_IDLE) && !mem_busy;
  assign accept   = in_valid && in_ready;
  assign step_go  = accept && (in_data.req_type == REQ_STEP) && active_r;
  assign pixel    = (pos_r >= POS_PIX_FIRST);
  assign group    = pos_r - POS_PIX_FIRST;
  assign band_sel = (band_r > BAND_LAST) ? 3'd0 : band_r;
  assign pos_inc  = pos_r + 1'b1;
  assign row_inc  = row_r + 1'b1;
  assign last     = (pos_inc >= ROW_BYTES) && (row_inc >= end_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (step_go) begin
          state_nxt = pixel ? ST_GATHER : ST_RESULT;
        end
      end
      ST_GATHER: begin
        if (cnt_r == GATHER_CNT) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    band_nxt    = band_r;
    active_nxt  = active_r;
    row_nxt     = row_r;
    end_nxt     = end_r;
    pos_nxt     = pos_r;
    cnt_nxt     = cnt_r;
    acc_nxt     = acc_r;
    is_data_nxt = is_data_r;
    mem_req     = '0;
    res_push    = 1'b0;
    res_data    = '{bus_byte: acc_r, is_data: is_data_r,
                    last_of_refresh: last, next_band: band_r};
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.req_type)
            REQ_WRITE: begin
              mem_req.we    = 1'b1;
              mem_req.addr  = in_data.fb_address;
              mem_req.wdata = in_data.fb_data;
            end
            REQ_START: begin
              if (in_data.full_refresh) begin
                row_nxt  = '0;
                end_nxt  = FULL_STOP;
                band_nxt = '0;
              end else begin
                row_nxt  = band_first(band_sel);
                end_nxt  = band_stop(band_sel);
                band_nxt = (band_sel == BAND_LAST) ? 3'd0 : band_sel + 1'b1;
              end
              pos_nxt    = '0;
              active_nxt = 1'b1;
            end
            REQ_STEP: begin
              if (active_r) begin
                if (pixel) begin
                  // first of eight column reads
                  mem_req.re  = 1'b1;
                  mem_req.addr = {row_r[5:3], group[3:0], 3'd0};
                  cnt_nxt     = 4'd1;
                  acc_nxt     = '0;
                  is_data_nxt = 1'b1;
                end else begin
                  is_data_nxt = 1'b0;
                  if (pos_r == POS_VCMD) begin
                    // upper and lower halves share row[4:0]
                    acc_nxt = CMD_BASE | {3'b000, row_r[4:0]};
                  end else begin
                    acc_nxt = row_r[5] ? CMD_LOWER : CMD_BASE;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_GATHER: begin
        // collect previous read, MSB first
        acc_nxt = {acc_r[6:0], mem_rdata[row_r[2:0]]};
        if (cnt_r != GATHER_CNT) begin
          cnt_nxt      = cnt_r + 1'b1;
          mem_req.re   = 1'b1;
          mem_req.addr = {row_r[5:3], group[3:0], cnt_r[2:0]};
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          res_push = 1'b1;
          if (pos_inc >= ROW_BYTES) begin
            pos_nxt = '0;
            row_nxt = row_inc;
            if (row_inc >= end_r) begin
              active_nxt = 1'b0;
            end
          end else begin
            pos_nxt = pos_inc;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      band_r   <= '0;
      active_r <= 1'b0;
      row_r    <= '0;
      end_r    <= '0;
      pos_r    <= '0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      band_r   <= band_nxt;
      active_r <= active_nxt;
      row_r    <= row_nxt;
      end_r    <= end_nxt;
      pos_r    <= pos_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    is_data_r <= is_data_nxt;
  end

  // Engine stays put while the framebuffer is being cleared
  a_idle_while_clear: assert property (@(posedge clk) disable iff (!rst_n)
    mem_busy |-> state_r == ST_IDLE)
    else $error("engine busy during clearing sweep");

  // Gather counter never passes eight reads
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= GATHER_CNT)
    else $error("gather counter out of range");

  // A result is pushed only into a free output stage
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> out_free)
    else $error("result pushed into full output stage");

  // Byte position stays inside one row
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < ROW_BYTES)
    else $error("byte position out of range");

  // A pixel step enters gathering with the first read already issued
  a_gather_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && state_nxt == ST_GATHER) |-> mem_req.re)
    else $error("gather started without first read");

endmodule

// ===== bench/tb.sv =====
module tb;
  import p2rlcd_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // One row of the directed sequence; want is only used where typed is set
  typedef struct packed {
    p2rlcd_in_t  item;
    logic        typed;
    p2rlcd_out_t want;
  } dir_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  p2rlcd_in_t  in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  p2rlcd_out_t out_data;

  // Mirror of the engine state
  logic [7:0] fb_mirror [FB_DEPTH];
  logic [2:0] m_band = '0;
  logic       m_active = 1'b0;
  logic [6:0] m_row = '0;
  logic [6:0] m_end = '0;
  logic [4:0] m_pos = '0;

  p2rlcd_out_t expected_bytes[$];
  int          mismatches = 0;
  int          counted = 0;
  int          send_idle_pct = 0;
  int          ready_idle_pct = 0;

  page_to_row_lcd_refresh_engine_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    for (int a = 0; a < FB_DEPTH; a++) fb_mirror[a] = 8'h00;
  end

  // Apply one request to the mirror; returns 1 when a bus byte comes out
  function automatic bit predict_bus_byte(input p2rlcd_in_t rq, output p2rlcd_out_t res,
                                          output bit ignored);
    logic [5:0] row;
    logic [2:0] b;
    logic [4:0] grp;
    logic [9:0] base;
    res = '0;
    ignored = 1'b0;
    predict_bus_byte = 1'b0;
    case (rq.req_type)
      REQ_WRITE: begin
        fb_mirror[rq.fb_address] = rq.fb_data;
      end
      REQ_START: begin
        if (rq.full_refresh) begin
          m_row  = '0;
          m_end  = FULL_STOP;
          m_band = '0;
        end else begin
          b      = (m_band <= BAND_LAST) ? m_band : 3'd0;
          // bands are 13 rows apart; the last one runs to the bottom
          m_row  = 7'(13 * b);
          m_end  = (b == BAND_LAST) ? FULL_STOP : 7'(13 * (b + 1));
          m_band = (b == BAND_LAST) ? 3'd0 : b + 3'd1;
        end
        m_pos    = POS_VCMD;
        m_active = 1'b1;
      end
      REQ_STEP: begin
        if (!m_active) begin
          ignored = 1'b1;
        end else begin
          row = m_row[5:0];
          if (m_pos == POS_VCMD) begin
            // lower half folds back onto rows 0..31
            res.bus_byte = CMD_BASE | {3'b000, row[4:0]};
          end else if (m_pos == POS_HCMD) begin
            res.bus_byte = row[5] ? CMD_LOWER : CMD_BASE;
          end else begin
            grp  = m_pos - POS_PIX_FIRST;
            base = {row[5:3], grp[3:0], 3'b000};
            for (int i = 0; i < 8; i++) res.bus_byte[7 - i] = fb_mirror[base + 10'(i)][row[2:0]];
            res.is_data = 1'b1;
          end
          m_pos = m_pos + 5'd1;
          if (m_pos >= ROW_BYTES) begin
            m_pos = POS_VCMD;
            m_row = m_row + 7'd1;
            if (m_row >= m_end) begin
              m_active            = 1'b0;
              res.last_of_refresh = 1'b1;
            end
          end
          res.next_band    = m_band;
          predict_bus_byte = 1'b1;
        end
      end
      default: ignored = 1'b1;
    endcase
  endfunction

  // Present one transaction, wait for acceptance, then queue its bus byte
  task automatic issue_request(input p2rlcd_in_t it, input logic typed, input p2rlcd_out_t want);
    p2rlcd_out_t res;
    bit          ign;
    bit          got;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    got = predict_bus_byte(it, res, ign);
    if (got) expected_bytes.push_back(typed ? want : res);
    if (!ign) counted++;
  endtask

  function automatic p2rlcd_in_t rand_item(input logic [1:0] req);
    p2rlcd_in_t it;
    it.req_type     = req;
    it.fb_address   = 10'($urandom);
    it.fb_data      = 8'($urandom);
    it.full_refresh = 1'($urandom);
    return it;
  endfunction

  function automatic dir_row_t mk_row(input logic [1:0] req, input logic [9:0] addr,
                                      input logic [7:0] dat, input logic full,
                                      input logic typed, input logic [7:0] bb,
                                      input logic isd, input logic lst, input logic [2:0] nb);
    dir_row_t r;
    r.item  = '{req_type: req, fb_address: addr, fb_data: dat, full_refresh: full};
    r.typed = typed;
    r.want  = '{bus_byte: bb, is_data: isd, last_of_refresh: lst, next_band: nb};
    return r;
  endfunction

  // Result side: random back-pressure and in-order compare
  always @(posedge clk) begin : result_check
    p2rlcd_out_t want;
    out_ready <= ($urandom_range(99) >= ready_idle_pct);
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        mismatches++;
        $display("%0t unexpected transaction: expected none, got %h", $time, out_data);
      end else begin
        want = expected_bytes.pop_front();
        if (out_data.bus_byte !== want.bus_byte) begin
          mismatches++;
          $display("%0t bus_byte: expected %h, got %h", $time, want.bus_byte, out_data.bus_byte);
        end
        if (out_data.is_data !== want.is_data) begin
          mismatches++;
          $display("%0t is_data: expected %b, got %b", $time, want.is_data, out_data.is_data);
        end
        if (out_data.last_of_refresh !== want.last_of_refresh) begin
          mismatches++;
          $display("%0t last_of_refresh: expected %b, got %b", $time,
                   want.last_of_refresh, out_data.last_of_refresh);
        end
        if (out_data.next_band !== want.next_band) begin
          mismatches++;
          $display("%0t next_band: expected %0d, got %0d", $time, want.next_band,
                   out_data.next_band);
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t   dir_rows[$];
    p2rlcd_in_t it;
    int         r;
    int         n;
    bit         run_out;

    // Directed: idle step, unused code, extremes, bands in order, live writes, restarts
    dir_rows.push_back(mk_row(REQ_STEP,   10'h000, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0));
    dir_rows.push_back(mk_row(REQ_UNUSED, 10'h3FF, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0));
    dir_rows.push_back(mk_row(REQ_WRITE,  10'h000, 8'h81, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0));
    dir_rows.push_back(mk_row(REQ_WRITE,  10'h3FF, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0));
    dir_rows.push_back(mk_row(REQ_WRITE,  10'h2AA, 8'h55, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0));
    dir_rows.push_back(mk_row(REQ_WRITE,  10'h155, 8'hAA, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0));
    dir_rows.push_back(mk_row(REQ_START,  10'h000, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0));
    dir_rows.push_back(mk_row(REQ_STEP,   10'h000, 8'h00, 1'b0, 1'b1, 8'h80, 1'b0, 1'b0, 3'd0));
    dir_rows.push_back(mk_row(REQ_STEP,   10'h3FF, 8'hFF, 1'b1, 1'b1, 8'h80, 1'b0, 1'b0, 3'd0));
    dir_rows.push_back(mk_row(REQ_STEP,   10'h000, 8'h00, 1'b0, 1'b1, 8'h80, 1'b1, 1'b0, 3'd0));
    // write lands in the group about to be sent
    dir_rows.push_back(mk_row(REQ_WRITE,  10'h00F, 8'h01, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0));
    dir_rows.push_back(mk_row(REQ_STEP,   10'h000, 8'h00, 1'b0, 1'b1, 8'h01, 1'b1, 1'b0, 3'd0));
    // partial start abandons the full refresh
    dir_rows.push_back(mk_row(REQ_START,  10'h000, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0));
    dir_rows.push_back(mk_row(REQ_STEP,   10'h000, 8'h00, 1'b0, 1'b1, 8'h80, 1'b0, 1'b0, 3'd1));
    dir_rows.push_back(mk_row(REQ_START,  10'h000, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0));
    dir_rows.push_back(mk_row(REQ_STEP,   10'h000, 8'h00, 1'b0, 1'b1, 8'h8D, 1'b0, 1'b0, 3'd2));
    dir_rows.push_back(mk_row(REQ_STEP,   10'h000, 8'h00, 1'b0, 1'b1, 8'h80, 1'b0, 1'b0, 3'd2));
    dir_rows.push_back(mk_row(REQ_STEP,   10'h000, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0));
    dir_rows.push_back(mk_row(REQ_START,  10'h000, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0));
    dir_rows.push_back(mk_row(REQ_START,  10'h000, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0));
    dir_rows.push_back(mk_row(REQ_STEP,   10'h000, 8'h00, 1'b0, 1'b1, 8'h87, 1'b0, 1'b0, 3'd4));
    dir_rows.push_back(mk_row(REQ_STEP,   10'h000, 8'h00, 1'b0, 1'b1, 8'h88, 1'b0, 1'b0, 3'd4));
    // last band wraps the index back to zero
    dir_rows.push_back(mk_row(REQ_START,  10'h000, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0));
    dir_rows.push_back(mk_row(REQ_STEP,   10'h000, 8'h00, 1'b0, 1'b1, 8'h94, 1'b0, 1'b0, 3'd0));
    dir_rows.push_back(mk_row(REQ_STEP,   10'h000, 8'h00, 1'b0, 1'b1, 8'h88, 1'b0, 1'b0, 3'd0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct  = 33;
    ready_idle_pct = 86;
    foreach (dir_rows[k]) issue_request(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);

    // Random: refresh sessions with live writes, some abandoned, some run out
    counted = 0;
    for (int ph = 0; ph < 3; ph++) begin
      if (ph > 0) begin
        // hold off until the engine has drained
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge clk);
      end
      send_idle_pct  = (ph == 0) ? 33 : (ph == 1) ? 86 : 0;
      ready_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 33 : 0;
      while (counted < 450 * (ph + 1)) begin
        r = $urandom_range(99);
        if (r < 6) begin
          issue_request(rand_item(2'($urandom_range(3))), 1'b0, '0);
        end else begin
          it = rand_item(REQ_START);
          it.full_refresh = ($urandom_range(7) == 0);
          run_out = !it.full_refresh && ($urandom_range(9) < 7);
          n = $urandom_range(1, 150);
          issue_request(it, 1'b0, '0);
          while (m_active && (run_out || n > 0)) begin
            r = $urandom_range(99);
            if (r < 12) begin
              it = rand_item(REQ_WRITE);
              // mostly hit the page being sent
              if (r < 8) it.fb_address[9:7] = m_row[5:3];
            end else if (r < 14) begin
              it = rand_item(REQ_UNUSED);
            end else begin
              it = rand_item(REQ_STEP);
              n--;
            end
            issue_request(it, 1'b0, '0);
          end
        end
      end
    end

    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
